// ----- rtl/core/swe_pkg.sv -----
// ----------------------------------------------------------------------------
// swe_pkg
// Shared constants and types for the erase-by-value stack.
// ----------------------------------------------------------------------------
package swe_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_ERASE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Per-transfer control broadcast to every cell
  typedef struct packed {
    logic                     en;
    logic                     push;
    logic                     pop;
    logic                     erase;
    logic signed [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/swe_if.sv -----
// ----------------------------------------------------------------------------
// swe_if
// Request and response channels of the erase-by-value stack.
// ----------------------------------------------------------------------------
interface swe_req_if;
  import swe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface swe_rsp_if;
  import swe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  top_value;
  logic [COUNT_OUT_W-1:0]    entry_count;
  logic [1:0]                status;

  modport source (output valid, output top_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input top_value, input entry_count, input status,
                  output ready);
endinterface

// ----- rtl/core/swe_cell.sv -----
// ----------------------------------------------------------------------------
// swe_cell
// One stack slot. Cell 0 is the top; push shifts towards higher slots,
// pop and erase pull from the slot below.
// ----------------------------------------------------------------------------
module swe_cell
  import swe_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occupied_i,
  input  logic                     full_i,
  input  logic                     found_i,
  input  logic signed [DATA_W-1:0] above_i,
  input  logic signed [DATA_W-1:0] below_i,
  output logic                     found_o,
  output logic signed [DATA_W-1:0] entry_o,
  output logic signed [DATA_W-1:0] entry_d_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic                     hit;

  assign hit     = occupied_i && (entry_q == ctrl_i.key);
  assign found_o = found_i || hit;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.en) begin
      if (ctrl_i.push && !full_i) begin
        entry_d = above_i;
      end else if (ctrl_i.pop) begin
        entry_d = below_i;
      end else if (ctrl_i.erase && found_o) begin
        entry_d = below_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

// ----- rtl/core/stack_with_erase_by_value.sv -----
// ----------------------------------------------------------------------------
// stack_with_erase_by_value
// Bounded LIFO stack of signed 32-bit values with push, pop, clear and
// erase of the first matching value from the top.
// ----------------------------------------------------------------------------
// One request is taken per cycle and its response is captured in the output
// register when the request transfers; a new request is taken only while
// the output register is empty or its response transfers in the same cycle,
// so a held-off response stalls the input. The stack is a row of STACK_DEPTH
// cells with the top in cell 0; every cell compares its entry with the erase
// key in parallel and a match flag ripples from the top through the row, so
// the depth of that chain sets the clock period. Stored entries are not
// cleared by reset or by clear; only the entry count is, and unoccupied
// cells are never read.
// ----------------------------------------------------------------------------
module stack_with_erase_by_value
  import swe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  swe_req_if.sink   req_i,
  swe_rsp_if.source rsp_o
);

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     full, empty, xfer;
  cell_ctrl_t               ctrl;
  logic [STACK_DEPTH-1:0]   occupied;
  logic [STACK_DEPTH:0]     found;
  logic signed [DATA_W-1:0] entry   [STACK_DEPTH];
  logic signed [DATA_W-1:0] entry_d [STACK_DEPTH];
  logic signed [DATA_W-1:0] top_d;
  status_e                  status_d;

  logic                     rsp_valid_q;
  logic signed [DATA_W-1:0] rsp_top_q;
  logic [COUNT_OUT_W-1:0]   rsp_count_q;
  status_e                  rsp_status_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign xfer        = req_i.valid && req_i.ready;

  assign full  = (count_q == CNT_W'(STACK_DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.en    = xfer;
  assign ctrl.push  = (kind_e'(req_i.kind) == KIND_PUSH);
  assign ctrl.pop   = (kind_e'(req_i.kind) == KIND_POP) && !empty;
  assign ctrl.erase = (kind_e'(req_i.kind) == KIND_ERASE);
  assign ctrl.key   = req_i.value;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] above, below;

    assign occupied[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_top
      assign above = req_i.value;
    end else begin : g_mid
      assign above = entry[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = entry[i];
    end else begin : g_nbot
      assign below = entry[i+1];
    end

    swe_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied[i]),
      .full_i     (full),
      .found_i    (found[i]),
      .above_i    (above),
      .below_i    (below),
      .found_o    (found[i+1]),
      .entry_o    (entry[i]),
      .entry_d_o  (entry_d[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    case (kind_e'(req_i.kind))
      KIND_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_d = ST_MISS;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      KIND_ERASE: begin
        if (found[STACK_DEPTH]) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign top_d = (count_d != '0) ? entry_d[0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      rsp_top_q    <= top_d;
      rsp_count_q  <= COUNT_OUT_W'(count_d);
      rsp_status_q <= status_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.top_value   = rsp_top_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.status      = rsp_status_q;

endmodule
